@@ rtl/rgbcm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbcm_pkg
// Shared types, constants and channel arithmetic for the contrast block.
// ----------------------------------------------------------------------------
package rgbcm_pkg;

   localparam int MaxPixels  = 1048576;
   localparam int QueueDepth = 2;

   typedef enum logic [1:0] {
      CMD_ACCUM,
      CMD_LAST,
      CMD_ADJUST
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   red;
      logic [7:0]   green;
      logic [7:0]   blue;
      logic [7:0]   alpha;
   } item_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_MEAN,
      ST_ADJ
   } back_state_type;

   // apply the sign to the scaled distance, add the mean back and clamp
   function automatic logic [7:0] finish_chan(logic neg, logic [16:0] mag, logic [7:0] avg);
      logic signed [18:0] v;
      v = neg ? (19'sd0 - $signed({2'b00, mag})) : $signed({2'b00, mag});
      v = v + $signed({11'b0, avg});
      if (v < 0) begin
         return 8'd0;
      end else if (v > 19'sd255) begin
         return 8'd255;
      end else begin
         return v[7:0];
      end
   endfunction

endpackage

@@ rtl/rgbcm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbcm_front
// Accepts pixels, classifies them into commands and queues them for the back.
// ----------------------------------------------------------------------------
module rgbcm_front import rgbcm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_opcode,
   input  logic [7:0] req_pixel_red,
   input  logic [7:0] req_pixel_green,
   input  logic [7:0] req_pixel_blue,
   input  logic [7:0] req_pixel_alpha,
   input  logic       req_end_of_pass,
   output logic       cmd_valid,
   output item_type   cmd_item,
   input  logic       cmd_take
);

   item_type   queue_ff [QueueDepth];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   item_new;
   logic       push_ok;
   logic       pop_ok;

   always_comb begin
      item_new.red   = req_pixel_red;
      item_new.green = req_pixel_green;
      item_new.blue  = req_pixel_blue;
      item_new.alpha = req_pixel_alpha;
      if (req_opcode) begin
         item_new.kind = CMD_ADJUST;
      end else if (req_end_of_pass) begin
         item_new.kind = CMD_LAST;
      end else begin
         item_new.kind = CMD_ACCUM;
      end
   end

   assign req_full  = (count_ff == 2'(QueueDepth));
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_item  = queue_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

@@ rtl/rgbcm_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbcm_divider
// Restoring divider, one quotient bit per cycle, 16 quotient bits.
// ----------------------------------------------------------------------------
module rgbcm_divider import rgbcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [27:0] numer,
   input  logic [20:0] denom,
   output logic        done,
   output logic [15:0] quot
);

   logic [27:0] rem_ff, rem_in;
   logic [35:0] dsh_ff, dsh_in;
   logic [15:0] quot_ff, quot_in;
   logic [3:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        fits;

   // caller guarantees the quotient stays below 2^16
   assign fits = ({8'b0, rem_ff} >= dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = numer;
         dsh_in  = {denom, 15'b0};
         quot_in = 16'd0;
         step_in = 4'd15;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff[27:0];
         end
         quot_in = {quot_ff[14:0], fits};
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff - 4'd1;
         if (step_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

@@ rtl/rgbcm_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbcm_back
// Executes queued commands: sums, mean division and per-channel adjustment.
// ----------------------------------------------------------------------------
module rgbcm_back import rgbcm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  item_type          cmd_item,
   output logic              cmd_take,
   input  logic              csr_write_enable,
   input  logic signed [8:0] csr_write_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_out_red,
   output logic [7:0]        rsp_out_green,
   output logic [7:0]        rsp_out_blue,
   output logic [7:0]        rsp_out_alpha
);

   back_state_type    state_ff, state_in;
   logic signed [8:0] amount_ff;
   logic [2:0][27:0]  sum_ff, sum_in;
   logic [20:0]       count_ff, count_in;
   logic [2:0][7:0]   mean_ff, mean_in;
   logic [2:0]        neg_ff, neg_in;
   logic [7:0]        alpha_ff, alpha_in;
   logic [2:0][7:0]   out_ff, out_in;
   logic [7:0]        out_alpha_ff, out_alpha_in;
   logic              out_valid_ff, out_valid_in;

   logic signed [8:0] amt;
   logic [8:0]        small_mult;
   logic [20:0]       big_den;
   logic              slot_free;
   logic              div_start;
   logic [2:0][27:0]  div_num;
   logic [20:0]       div_den;
   logic [2:0]        div_done;
   logic [2:0][15:0]  div_quot;
   logic [2:0][7:0]   pix;
   logic [2:0][9:0]   diff;
   logic [2:0][7:0]   mag;
   logic [2:0][16:0]  prod;
   logic [2:0][27:0]  sum_add;
   logic [20:0]       count_add;

   // most negative code acts as -255
   assign amt        = (amount_ff == -9'sd256) ? -9'sd255 : amount_ff;
   assign small_mult = 9'(10'sd256 + 10'(amt));
   assign big_den    = {13'b0, 8'(9'sd256 - amt)};
   assign slot_free  = !out_valid_ff || rsp_pop;
   assign pix        = {cmd_item.blue, cmd_item.green, cmd_item.red};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i] = {2'b00, pix[i]} - {2'b00, mean_ff[i]};
         mag[i]  = diff[i][9] ? 8'(10'd0 - diff[i]) : diff[i][7:0];
         prod[i] = mag[i] * small_mult;
      end
   end

   always_comb begin
      if (count_ff < 21'(MaxPixels)) begin
         for (int i = 0; i < 3; i++) begin
            sum_add[i] = sum_ff[i] + {20'b0, pix[i]};
         end
         count_add = count_ff + 21'd1;
      end else begin
         sum_add   = sum_ff;
         count_add = count_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      mean_in      = mean_ff;
      neg_in       = neg_ff;
      alpha_in     = alpha_ff;
      out_in       = out_ff;
      out_alpha_in = out_alpha_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      cmd_take     = 1'b0;
      div_start    = 1'b0;
      div_num      = sum_add;
      div_den      = count_add;
      unique case (state_ff)
         ST_RUN: begin
            if (cmd_valid) begin
               unique case (cmd_item.kind)
                  CMD_ACCUM: begin
                     cmd_take = 1'b1;
                     sum_in   = sum_add;
                     count_in = count_add;
                  end
                  CMD_LAST: begin
                     cmd_take = 1'b1;
                     sum_in   = '0;
                     count_in = 21'd0;
                     if (count_add == 21'd0) begin
                        mean_in = '0;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_MEAN;
                     end
                  end
                  CMD_ADJUST: begin
                     if (slot_free) begin
                        cmd_take = 1'b1;
                        if (amt > 9'sd0) begin
                           for (int i = 0; i < 3; i++) begin
                              neg_in[i]  = diff[i][9];
                              div_num[i] = {12'b0, mag[i], 8'b0};
                           end
                           div_den   = big_den;
                           div_start = 1'b1;
                           alpha_in  = cmd_item.alpha;
                           state_in  = ST_ADJ;
                        end else begin
                           for (int i = 0; i < 3; i++) begin
                              out_in[i] = finish_chan(diff[i][9], {8'b0, prod[i][16:8]},
                                                      mean_ff[i]);
                           end
                           out_alpha_in = cmd_item.alpha;
                           out_valid_in = 1'b1;
                        end
                     end
                  end
                  default: begin
                     cmd_take = 1'b1;
                  end
               endcase
            end
         end
         ST_MEAN: begin
            if (div_done[0]) begin
               for (int i = 0; i < 3; i++) begin
                  mean_in[i] = div_quot[i][7:0];
               end
               state_in = ST_RUN;
            end
         end
         ST_ADJ: begin
            // slot was free when the transfer was taken and nothing else fills it
            if (div_done[0]) begin
               for (int i = 0; i < 3; i++) begin
                  out_in[i] = finish_chan(neg_ff[i], {1'b0, div_quot[i]}, mean_ff[i]);
               end
               out_alpha_in = alpha_ff;
               out_valid_in = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   for (genvar g = 0; g < 3; g++) begin : g_div
      rgbcm_divider u_div (
         .clock (clock),
         .reset (reset),
         .start (div_start),
         .numer (div_num[g]),
         .denom (div_den),
         .done  (div_done[g]),
         .quot  (div_quot[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         amount_ff    <= 9'sd0;
         sum_ff       <= '0;
         count_ff     <= 21'd0;
         mean_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_write_enable) begin
            amount_ff <= csr_write_data;
         end
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff       <= neg_in;
      alpha_ff     <= alpha_in;
      out_ff       <= out_in;
      out_alpha_ff <= out_alpha_in;
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_out_red   = out_ff[0];
   assign rsp_out_green = out_ff[1];
   assign rsp_out_blue  = out_ff[2];
   assign rsp_out_alpha = out_alpha_ff;

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RUN) |-> !cmd_take)
      else $error("command taken while divider busy");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done[0] |-> (state_ff == ST_MEAN || state_ff == ST_ADJ))
      else $error("divider finished outside a wait state");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> (out_valid_ff && $stable(out_ff)))
      else $error("pending result lost or overwritten");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 21'(MaxPixels))
      else $error("pixel count beyond limit");

endmodule

@@ rtl/rgb_contrast_around_mean.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_contrast_around_mean
// Two-pass RGBA contrast adjustment around per-channel means.
// ----------------------------------------------------------------------------
// Accumulate pixels (opcode 0) are taken one per cycle. The accumulate pixel
// with end_of_pass set starts a 16-step restoring divide of the three sums by
// the pixel count, during which no further pixel is executed.
// Adjust pixels (opcode 1) use a small multiply when contrast_amount is zero
// or negative, each taken once the result register is free; with a positive
// amount each runs through the same 16-step divider before the next pixel
// is executed. A two-entry queue between the input side and the execution
// side, and a one-entry result register, let each side stall on its own.
module rgb_contrast_around_mean import rgbcm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_opcode,
   input  logic [7:0]        req_pixel_red,
   input  logic [7:0]        req_pixel_green,
   input  logic [7:0]        req_pixel_blue,
   input  logic [7:0]        req_pixel_alpha,
   input  logic              req_end_of_pass,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_out_red,
   output logic [7:0]        rsp_out_green,
   output logic [7:0]        rsp_out_blue,
   output logic [7:0]        rsp_out_alpha,
   input  logic              csr_write_enable,
   input  logic signed [8:0] csr_write_data
);

   logic     cmd_valid;
   item_type cmd_item;
   logic     cmd_take;

   rgbcm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_pixel_red   (req_pixel_red),
      .req_pixel_green (req_pixel_green),
      .req_pixel_blue  (req_pixel_blue),
      .req_pixel_alpha (req_pixel_alpha),
      .req_end_of_pass (req_end_of_pass),
      .cmd_valid       (cmd_valid),
      .cmd_item        (cmd_item),
      .cmd_take        (cmd_take)
   );

   rgbcm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd_item         (cmd_item),
      .cmd_take         (cmd_take),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_alpha    (rsp_out_alpha)
   );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mean-based contrast block. A two-pass pixel
// stream (accumulate pass, then adjust pixels) is pushed through the request
// queue. An in-bench predictor tracks the sums and means and forms the
// expected adjusted pixel, which is checked against each popped result.
// ----------------------------------------------------------------------------
module tb;
   import rgbcm_pkg::*;

   localparam int CycleLimit = 1000000;
   localparam int SettleCycles = 60;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_type;

   logic              clock;
   logic              reset;
   logic              req_push;
   logic              req_full;
   logic              req_opcode;
   logic [7:0]        req_pixel_red;
   logic [7:0]        req_pixel_green;
   logic [7:0]        req_pixel_blue;
   logic [7:0]        req_pixel_alpha;
   logic              req_end_of_pass;
   logic              rsp_empty;
   logic              rsp_pop;
   logic [7:0]        rsp_out_red;
   logic [7:0]        rsp_out_green;
   logic [7:0]        rsp_out_blue;
   logic [7:0]        rsp_out_alpha;
   logic              csr_write_enable;
   logic signed [8:0] csr_write_data;

   localparam logic OpAccum  = 1'b0;
   localparam logic OpAdjust = 1'b1;

   // predictor state
   logic signed [8:0] amount;
   logic [27:0]       sum_red, sum_green, sum_blue;
   logic [20:0]       count;
   logic [7:0]        mean_red, mean_green, mean_blue;
   pixel_type         pending_pixels[$];

   int  errors;
   int  cycles;
   int  hold_count;
   bit  idle_on;
   bit  long_hold_req;

   rgb_contrast_around_mean dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   task automatic report(string what, int got, int want);
      $display("tb: mismatch %s got %0d want %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   function automatic logic [7:0] contrast_chan(logic [7:0] level, logic [7:0] avg);
      int c;
      int d;
      int v;
      int a;
      c = amount;
      if (c < -255) c = -255;
      if (c == 0) return level;
      a = int'(avg);
      d = int'(level) - a;
      if (c > 0) v = d * 256 / (256 - c) + a;
      else v = d * (256 + c) / 256 + a;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   function automatic void model_pixel(logic op, pixel_type p, logic last);
      pixel_type q;
      if (op == OpAccum) begin
         if (count < MaxPixels) begin
            sum_red   += p.red;
            sum_green += p.green;
            sum_blue  += p.blue;
            count++;
         end
         if (last) begin
            if (count != 0) begin
               mean_red   = 8'(sum_red / count);
               mean_green = 8'(sum_green / count);
               mean_blue  = 8'(sum_blue / count);
            end else begin
               mean_red = 0; mean_green = 0; mean_blue = 0;
            end
            sum_red = 0; sum_green = 0; sum_blue = 0; count = 0;
         end
      end else begin
         q.red   = contrast_chan(p.red, mean_red);
         q.green = contrast_chan(p.green, mean_green);
         q.blue  = contrast_chan(p.blue, mean_blue);
         q.alpha = p.alpha;
         pending_pixels.push_back(q);
      end
   endfunction

   // one transfer on the request side; called at a rising edge
   task automatic push_pixel(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic [7:0] a, logic last);
      pixel_type p;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      p.red = r; p.green = g; p.blue = b; p.alpha = a;
      req_push        <= 1'b1;
      req_opcode      <= op;
      req_pixel_red   <= r;
      req_pixel_green <= g;
      req_pixel_blue  <= b;
      req_pixel_alpha <= a;
      req_end_of_pass <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      model_pixel(op, p, last);
   endtask

   task automatic push_random(logic op, logic last);
      push_pixel(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), last);
   endtask

   task automatic drain;
      req_push <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic set_contrast(logic signed [8:0] v);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      amount = v;
   endtask

   // result side: check each transfer, then choose pop for the next edge
   always @(posedge clock) begin
      pixel_type w;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_pixels.size() == 0) begin
            report("unexpected result", 0, 0);
         end else begin
            w = pending_pixels.pop_front();
            if (rsp_out_red !== w.red) report("red", rsp_out_red, w.red);
            if (rsp_out_green !== w.green) report("green", rsp_out_green, w.green);
            if (rsp_out_blue !== w.blue) report("blue", rsp_out_blue, w.blue);
            if (rsp_out_alpha !== w.alpha) report("alpha", rsp_out_alpha, w.alpha);
         end
      end
      if (hold_count > 0) begin
         rsp_pop <= 1'b0;
         hold_count--;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_count = 300;
         rsp_pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_pop <= 1'b0;
         hold_count = $urandom_range(0, 5);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   task automatic test_before_averaging;
      set_contrast(9'sd100);
      push_pixel(OpAdjust, 8'd0, 8'd255, 8'd128, 8'd7, 1'b0);
      push_pixel(OpAdjust, 8'd255, 8'd0, 8'd1, 8'd255, 1'b1);
   endtask

   task automatic test_directed;
      set_contrast(9'sd255);
      push_pixel(OpAccum, 8'd0, 8'd255, 8'd10, 8'd0, 1'b0);
      push_pixel(OpAccum, 8'd255, 8'd0, 8'd200, 8'd0, 1'b1);
      push_pixel(OpAdjust, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      push_pixel(OpAdjust, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
      push_pixel(OpAdjust, 8'd127, 8'd127, 8'd105, 8'd1, 1'b0);
      // end of pass on an adjust pixel is ignored
      push_pixel(OpAdjust, 8'd128, 8'd126, 8'd106, 8'd2, 1'b1);
      set_contrast(-9'sd256);
      push_pixel(OpAdjust, 8'd0, 8'd255, 8'd3, 8'd3, 1'b0);
      set_contrast(-9'sd255);
      push_pixel(OpAdjust, 8'd255, 8'd0, 8'd200, 8'd4, 1'b0);
      set_contrast(9'sd1);
      push_pixel(OpAdjust, 8'd0, 8'd255, 8'd50, 8'd5, 1'b0);
      set_contrast(-9'sd1);
      push_pixel(OpAdjust, 8'd255, 8'd0, 8'd50, 8'd6, 1'b0);
      set_contrast(9'sd0);
      push_pixel(OpAdjust, 8'd17, 8'd99, 8'd240, 8'd8, 1'b0);
      push_pixel(OpAccum, 8'd9, 8'd9, 8'd9, 8'd9, 1'b1);
      set_contrast(9'sd128);
      push_pixel(OpAdjust, 8'd0, 8'd255, 8'd9, 8'd9, 1'b0);
   endtask

   // fill the queue while the receiver holds off
   task automatic test_backpressure;
      set_contrast(9'sd0);
      long_hold_req = 1'b1;
      repeat (20) push_random(OpAdjust, 1'($urandom));
      set_contrast(-9'sd60);
      long_hold_req = 1'b1;
      repeat (20) push_random(OpAdjust, 1'b0);
   endtask

   task automatic test_random(int items);
      int sent;
      int n;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0: set_contrast(9'sd255);
               1: set_contrast(-9'sd256);
               2: set_contrast(9'sd0);
               default: set_contrast(9'($urandom));
            endcase
         end
         if (sent > items - 200) idle_on = 1'b0;
         if ($urandom_range(0, 4) == 0) begin
            // noise: loose mix of operations and end markers
            n = $urandom_range(3, 12);
            repeat (n) push_random(1'($urandom), $urandom_range(0, 5) == 0);
         end else begin
            n = $urandom_range(1, 16);
            repeat (n - 1) push_random(OpAccum, 1'b0);
            push_random(OpAccum, 1'b1);
            sent += n;
            n = $urandom_range(4, 30);
            repeat (n) push_random(OpAdjust, $urandom_range(0, 7) == 0);
         end
         sent += n;
      end
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      hold_count = 0;
      idle_on = 1'b1;
      long_hold_req = 1'b0;
      amount = 0;
      sum_red = 0; sum_green = 0; sum_blue = 0; count = 0;
      mean_red = 0; mean_green = 0; mean_blue = 0;
      reset = 1'b1;
      req_push = 1'b0;
      req_opcode = 1'b0;
      req_pixel_red = 0;
      req_pixel_green = 0;
      req_pixel_blue = 0;
      req_pixel_alpha = 0;
      req_end_of_pass = 1'b0;
      rsp_pop = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_before_averaging();
      test_directed();
      test_backpressure();
      test_random(1800);
      drain();
      if (errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/rgbcm_pkg.sv
rtl/rgbcm_front.sv
rtl/rgbcm_divider.sv
rtl/rgbcm_back.sv
rtl/rgb_contrast_around_mean.sv
verif/tb.sv
